// ===== rtl/atdt_pkg.sv =====
// Package with the types, codes and constants of the atom term decoder.
`default_nettype none

package atdt_pkg;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_IDX_W   = 1;

  // Bit places inside the result stream's tuser.
  localparam int unsigned TUSER_VALID_BIT = 0;
  localparam int unsigned TUSER_DONE_BIT  = 1;
  localparam int unsigned TUSER_ERROR_BIT = 2;

  // Bit places inside the result stream's tdata.
  localparam int unsigned TDATA_SRC_BIT  = 8;
  localparam int unsigned TDATA_RES_LSB  = 9;
  localparam int unsigned TDATA_CONS_LSB = 11;
  localparam int unsigned TDATA_CONS_MSB = 27;

  // Tag bytes.
  localparam logic [7:0] TAG_LATIN1_LONG  = 8'd100;
  localparam logic [7:0] TAG_LATIN1_SHORT = 8'd115;
  localparam logic [7:0] TAG_UTF8_LONG    = 8'd118;
  localparam logic [7:0] TAG_UTF8_SHORT   = 8'd119;

  // Byte patterns used by the transcoding.
  localparam logic [7:0] BYTE_HIGH_BIT = 8'h80;
  localparam logic [7:0] LEAD_MASK     = 8'hFE;
  localparam logic [7:0] LEAD_BASE     = 8'hC2;
  localparam logic [7:0] LEAD_OUT      = 8'hC0;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] LOW6_MASK     = 8'h3F;

  // Encoding mask bits of the wanted_encoding register.
  localparam logic [2:0] WANT_ASCII  = 3'b001;
  localparam logic [2:0] WANT_LATIN1 = 3'b010;
  localparam logic [2:0] WANT_UTF8   = 3'b100;

  // Held UTF-8 lead codes.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_C2   = 2'd1;
  localparam logic [1:0] HELD_C3   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WANTED = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_L2U  = 2'd1,
    MODE_U2L  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ENC_ASCII  = 2'd0,
    ENC_LATIN1 = 2'd1,
    ENC_UTF8   = 2'd2
  } enc_e;

  typedef struct packed {
    logic [16:0] consumed_count;
    logic [1:0]  result_encoding;
    logic        source_encoding;
    logic        error;
    logic        done_res;
    logic        last;
    logic        out_valid;
    logic [7:0]  out_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/atom_term_decode_transcode.sv =====
// Top level of the streaming atom decoder with Latin-1 and UTF-8 transcoding.
`default_nettype none

// Channel   | Direction | Payload                                  | Handshake
// ----------+-----------+------------------------------------------+------------------------
// s_axis    | in        | tdata: in_byte; tuser: restart           | tvalid and tready high
// m_axis    | out       | tdata: byte, encodings, count; tuser:    | tvalid and tready high
//           |           | out_valid, done_res, error; tlast: last  |
// cfg       | in        | cfg_index_i, cfg_data_i                  | cfg_valid_i, cfg_ready_o
//
// An accepted item is held in the input register; the decode stage then updates the state
// and writes its zero, one or two results into a four-entry queue, from whose head the
// result stream is driven. One item is taken every cycle while each item yields at most one
// result and m_axis_tready is high; a Latin-1 byte widened to UTF-8 gives two results in turn.
// Decode fires only with room for two results, so a stall backs up to s_axis_tready safely.
// Reset clears the atom state, the queue and the registers (wanted_encoding 2, limit 256).

module atom_term_decode_transcode #(
  parameter int unsigned OUT_LIMIT_MAX = 1024
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Input stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [atdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [7:0] in_byte
  input  wire  [atdt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,   // [0] restart
  // Result stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // [7:0] out_byte, [8] source_encoding, [10:9] result_encoding,
  // [27:11] consumed_count, [31:28] zero
  output logic [atdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] out_valid, [1] done_res, [2] error
  output logic [atdt_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  output logic                                m_axis_tlast,   // last
  // Configuration write channel
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [atdt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [atdt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are taken in every cycle; a limit above
  // OUT_LIMIT_MAX is clipped to it.
  // ---------------------------------------------------------------------------
  logic [2:0]  wanted_q;
  logic [10:0] dest_limit_q;
  logic        cfg_we;
  logic        cfg_clip;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_clip    = {21'd0, cfg_data_i} > 32'(OUT_LIMIT_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q     <= atdt_pkg::WANT_LATIN1;
      dest_limit_q <= 11'd256;
    end else if (cfg_we) begin
      if (cfg_index_i == atdt_pkg::CFG_WANTED) begin
        wanted_q <= cfg_data_i[2:0];
      end else begin
        dest_limit_q <= cfg_clip ? 11'(OUT_LIMIT_MAX) : cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------------
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       proc_fire;
  logic       s_acc;

  logic [QCntW-1:0] q_cnt_q;

  // The decode stage needs room for the largest burst an item can cause.
  assign proc_fire     = in_vld_q && (q_cnt_q <= QCntW'(QDepth - 2));
  assign s_axis_tready = !in_vld_q || proc_fire;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q    <= s_axis_tdata[7:0];
      in_restart_q <= s_axis_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Atom state.
  // ---------------------------------------------------------------------------
  atdt_pkg::phase_e phase_q, phase_d;
  atdt_pkg::mode_e  mode_q, mode_d;
  logic             tag_q, tag_d;
  logic [15:0]      rem_q, rem_d;
  logic [10:0]      oc_q, oc_d;
  logic [16:0]      cons_q, cons_d;
  logic             sna_q, sna_d;
  logic [1:0]       held_q, held_d;

  atdt_pkg::result_t r0, r1;
  logic [1:0]        nres;

  // Encoding of the text delivered for a finished atom.
  function automatic logic [1:0] res_enc(input logic sna, input atdt_pkg::mode_e mode,
                                         input logic tag);
    logic [1:0] enc;
    if (!sna) begin
      enc = atdt_pkg::ENC_ASCII;
    end else begin
      unique case (mode)
        atdt_pkg::MODE_COPY: enc = tag ? atdt_pkg::ENC_UTF8 : atdt_pkg::ENC_LATIN1;
        atdt_pkg::MODE_L2U:  enc = atdt_pkg::ENC_UTF8;
        atdt_pkg::MODE_U2L:  enc = atdt_pkg::ENC_LATIN1;
        default:             enc = atdt_pkg::ENC_ASCII;
      endcase
    end
    return enc;
  endfunction

  always_comb begin : decode
    logic [7:0]        b;
    logic [10:0]       lim;
    atdt_pkg::phase_e  ph;
    logic              fail;
    logic              done_now;
    logic [1:0]        ne;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [2:0]        tag_bit;
    logic [1:0]        enc;

    b        = in_byte_q;
    lim      = (dest_limit_q == 11'd0) ? 11'd0 : dest_limit_q - 11'd1;
    ph       = in_restart_q ? atdt_pkg::PH_TAG : phase_q;
    fail     = 1'b0;
    done_now = 1'b0;
    ne       = 2'd0;
    byte0    = 8'd0;
    byte1    = 8'd0;
    tag_bit  = 3'd0;

    phase_d = phase_q;
    mode_d  = mode_q;
    tag_d   = tag_q;
    rem_d   = rem_q;
    oc_d    = oc_q;
    cons_d  = cons_q;
    sna_d   = sna_q;
    held_d  = held_q;

    if (proc_fire) begin
      unique case (ph)
        atdt_pkg::PH_TAG: begin
          cons_d = 17'd1;
          sna_d  = 1'b0;
          oc_d   = 11'd0;
          held_d = atdt_pkg::HELD_NONE;
          rem_d  = 16'd0;
          unique case (b)
            atdt_pkg::TAG_LATIN1_LONG: begin
              tag_d   = 1'b0;
              phase_d = atdt_pkg::PH_LEN_HI;
            end
            atdt_pkg::TAG_LATIN1_SHORT: begin
              tag_d   = 1'b0;
              phase_d = atdt_pkg::PH_LEN_LO;
            end
            atdt_pkg::TAG_UTF8_LONG: begin
              tag_d   = 1'b1;
              phase_d = atdt_pkg::PH_LEN_HI;
            end
            atdt_pkg::TAG_UTF8_SHORT: begin
              tag_d   = 1'b1;
              phase_d = atdt_pkg::PH_LEN_LO;
            end
            default: fail = 1'b1;
          endcase
          if (!fail) begin
            tag_bit = tag_d ? atdt_pkg::WANT_UTF8 : atdt_pkg::WANT_LATIN1;
            if ((wanted_q & tag_bit) != 3'd0 || wanted_q == atdt_pkg::WANT_ASCII) begin
              mode_d = atdt_pkg::MODE_COPY;
            end else begin
              mode_d = tag_d ? atdt_pkg::MODE_U2L : atdt_pkg::MODE_L2U;
            end
          end
        end
        atdt_pkg::PH_LEN_HI: begin
          rem_d   = {b, 8'h00};
          cons_d  = cons_q + 17'd1;
          phase_d = atdt_pkg::PH_LEN_LO;
        end
        atdt_pkg::PH_LEN_LO: begin
          rem_d  = {rem_q[15:8], b};
          cons_d = cons_q + 17'd1;
          if (mode_q == atdt_pkg::MODE_COPY && rem_d >= {5'd0, dest_limit_q}) begin
            fail = 1'b1;
          end else if (rem_d == 16'd0) begin
            // Empty atom: finished at once, without a text byte.
            phase_d  = atdt_pkg::PH_TAG;
            done_now = 1'b1;
          end else begin
            phase_d = atdt_pkg::PH_PAYLOAD;
          end
        end
        atdt_pkg::PH_PAYLOAD: begin
          cons_d = cons_q + 17'd1;
          rem_d  = rem_q - 16'd1;
          unique case (mode_q)
            atdt_pkg::MODE_COPY: begin
              if ((b & atdt_pkg::BYTE_HIGH_BIT) != 8'd0 &&
                  wanted_q == atdt_pkg::WANT_ASCII) begin
                fail = 1'b1;
              end else begin
                if ((b & atdt_pkg::BYTE_HIGH_BIT) != 8'd0) begin
                  sna_d = 1'b1;
                end
                oc_d  = oc_q + 11'd1;
                ne    = 2'd1;
                byte0 = b;
              end
            end
            atdt_pkg::MODE_L2U: begin
              if ((b & atdt_pkg::BYTE_HIGH_BIT) == 8'd0) begin
                if (oc_q >= lim) begin
                  fail = 1'b1;
                end else begin
                  oc_d  = oc_q + 11'd1;
                  ne    = 2'd1;
                  byte0 = b;
                end
              end else if ({1'b0, oc_q} + 12'd2 > {1'b0, lim}) begin
                // Both bytes of the sequence must fit.
                fail = 1'b1;
              end else begin
                oc_d  = oc_q + 11'd2;
                sna_d = 1'b1;
                ne    = 2'd2;
                byte0 = atdt_pkg::LEAD_OUT | {6'd0, b[7:6]};
                byte1 = atdt_pkg::BYTE_HIGH_BIT | (b & atdt_pkg::LOW6_MASK);
              end
            end
            atdt_pkg::MODE_U2L: begin
              if (held_q != atdt_pkg::HELD_NONE) begin
                if ((b & atdt_pkg::CONT_MASK) != atdt_pkg::BYTE_HIGH_BIT) begin
                  fail = 1'b1;
                end else begin
                  held_d = atdt_pkg::HELD_NONE;
                  sna_d  = 1'b1;
                  oc_d   = oc_q + 11'd1;
                  ne     = 2'd1;
                  byte0  = atdt_pkg::BYTE_HIGH_BIT | {1'b0, held_q[1], 6'd0} |
                           (b & atdt_pkg::LOW6_MASK);
                end
              end else if (oc_q >= lim) begin
                fail = 1'b1;
              end else if ((b & atdt_pkg::BYTE_HIGH_BIT) == 8'd0) begin
                oc_d  = oc_q + 11'd1;
                ne    = 2'd1;
                byte0 = b;
              end else if ((b & atdt_pkg::LEAD_MASK) == atdt_pkg::LEAD_BASE &&
                           rem_d != 16'd0) begin
                // Lead byte is held until its continuation byte arrives.
                held_d = b[0] ? atdt_pkg::HELD_C3 : atdt_pkg::HELD_C2;
              end else begin
                fail = 1'b1;
              end
            end
            default: fail = 1'b1;
          endcase
          if (!fail && ne != 2'd0 && rem_d == 16'd0) begin
            phase_d  = atdt_pkg::PH_TAG;
            done_now = 1'b1;
          end
        end
        atdt_pkg::PH_HALT: begin
          // Halted: the byte is dropped until a restart.
        end
        default: phase_d = atdt_pkg::PH_HALT;
      endcase
      if (fail) begin
        phase_d = atdt_pkg::PH_HALT;
      end
    end

    // Assemble the results of this item.
    enc = res_enc(sna_d, mode_d, tag_d);
    r0  = '0;
    r1  = '0;
    if (fail) begin
      nres     = 2'd1;
      r0.error = 1'b1;
      r0.last  = 1'b1;
    end else begin
      nres = (ne != 2'd0) ? ne : {1'b0, done_now};
      r0.out_byte  = byte0;
      r0.out_valid = (ne != 2'd0);
      r0.last      = (nres == 2'd1);
      if (done_now && nres == 2'd1) begin
        r0.done_res        = 1'b1;
        r0.source_encoding = tag_d;
        r0.result_encoding = enc;
        r0.consumed_count  = cons_d;
      end
      r1.out_byte  = byte1;
      r1.out_valid = 1'b1;
      r1.last      = 1'b1;
      if (done_now) begin
        r1.done_res        = 1'b1;
        r1.source_encoding = tag_d;
        r1.result_encoding = enc;
        r1.consumed_count  = cons_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= atdt_pkg::PH_TAG;
      mode_q  <= atdt_pkg::MODE_COPY;
      tag_q   <= 1'b0;
      rem_q   <= 16'd0;
      oc_q    <= 11'd0;
      cons_q  <= 17'd0;
      sna_q   <= 1'b0;
      held_q  <= atdt_pkg::HELD_NONE;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
      oc_q    <= oc_d;
      cons_q  <= cons_d;
      sna_q   <= sna_d;
      held_q  <= held_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. Up to two entries are written per cycle, one is read.
  // ---------------------------------------------------------------------------
  atdt_pkg::result_t q_mem_q [QDepth];
  logic [QPtrW-1:0]  q_wr_q;
  logic [QPtrW-1:0]  q_rd_q;
  logic [QPtrW-1:0]  q_wr_nxt;
  logic              q_pop;
  atdt_pkg::result_t q_head;

  assign q_pop    = m_axis_tvalid && m_axis_tready;
  assign q_wr_nxt = q_wr_q + QPtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      q_wr_q  <= q_wr_q + QPtrW'(nres);
      q_rd_q  <= q_rd_q + QPtrW'(q_pop);
      q_cnt_q <= q_cnt_q + QCntW'(nres) - QCntW'(q_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) begin
      q_mem_q[q_wr_q] <= r0;
    end
    if (nres == 2'd2) begin
      q_mem_q[q_wr_nxt] <= r1;
    end
  end

  assign q_head        = q_mem_q[q_rd_q];
  assign m_axis_tvalid = (q_cnt_q != '0);
  assign m_axis_tlast  = q_head.last;
  assign m_axis_tuser  = {q_head.error, q_head.done_res, q_head.out_valid};
  assign m_axis_tdata  = {4'd0, q_head.consumed_count, q_head.result_encoding,
                          q_head.source_encoding, q_head.out_byte};

endmodule

`default_nettype wire

// ===== rtl/atdt_checker.sv =====
// Port checker for the atom term decoder and its bind to the top level.
`default_nettype none

module atdt_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [atdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire [atdt_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  input wire                                m_axis_tlast
);

  // A held result keeps its contents until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // An error result stands alone: last, no text byte, not done.
  a_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[atdt_pkg::TUSER_ERROR_BIT] |->
      m_axis_tlast && !m_axis_tuser[atdt_pkg::TUSER_VALID_BIT] &&
      !m_axis_tuser[atdt_pkg::TUSER_DONE_BIT] && m_axis_tdata[7:0] == 8'd0)
    else $error("malformed error result");

  // Completion is always on the last result of an item and counts at least the tag and length.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[atdt_pkg::TUSER_DONE_BIT] |->
      m_axis_tlast &&
      m_axis_tdata[atdt_pkg::TDATA_CONS_MSB:atdt_pkg::TDATA_CONS_LSB] >= 17'd2)
    else $error("malformed done result");

  // Summary fields are zero unless the atom finished, and an empty slot has a zero byte.
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[atdt_pkg::TUSER_DONE_BIT] |->
      m_axis_tdata[atdt_pkg::OUT_TDATA_W-1:atdt_pkg::TDATA_SRC_BIT] == '0 &&
      (m_axis_tuser[atdt_pkg::TUSER_VALID_BIT] || m_axis_tdata[7:0] == 8'd0))
    else $error("summary fields set outside done");

endmodule

bind atom_term_decode_transcode atdt_checker u_atdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
